// ===== rtl/lcdni_pkg.sv =====
// shared types, constants and helpers of the character lcd nibble interface
`default_nettype none

package lcdni_pkg;

	// wait counter width default
	localparam int WAIT_COUNTER_BITS_DEF = 16;

	// sequence step encoding
	localparam int SEQ_STEP_BITS = 6;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_POWERUP   = 6'd0;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_INIT_NIB  = 6'd1;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_LAST_NIB3 = 6'd10;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_BYTES     = 6'd13;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_LAST_INIT = 6'd47;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_USER      = 6'd48;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_IDLE      = 6'd55;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_LONG_WAIT = 6'd3;
	localparam logic [SEQ_STEP_BITS-1:0] STEP_MID_WAIT  = 6'd6;

	// byte transfer sub-steps
	localparam logic [2:0] BK_HI_SET  = 3'd0;
	localparam logic [2:0] BK_HI_EN   = 3'd1;
	localparam logic [2:0] BK_HI_WAIT = 3'd2;
	localparam logic [2:0] BK_LO_SET  = 3'd3;
	localparam logic [2:0] BK_LO_EN   = 3'd4;
	localparam logic [2:0] BK_LO_WAIT = 3'd5;
	localparam logic [2:0] BK_POST    = 3'd6;

	// init sub-steps within each nibble group
	localparam logic [1:0] IN_SET  = 2'd0;
	localparam logic [1:0] IN_EN   = 2'd1;
	localparam logic [1:0] IN_WAIT = 2'd2;

	// init byte slots
	localparam logic [2:0] IB_FUNCTION = 3'd0;
	localparam logic [2:0] IB_DISPLAY  = 3'd1;
	localparam logic [2:0] IB_ENTRY    = 3'd2;
	localparam logic [2:0] IB_CLEAR    = 3'd3;

	// instruction and nibble constants
	localparam logic [7:0] INSTR_CLEAR  = 8'h01;
	localparam logic [7:0] INSTR_HOME   = 8'h02;
	localparam logic [3:0] NIB_WAKE     = 4'h3;
	localparam logic [3:0] NIB_FOURBIT  = 4'h2;
	localparam logic [15:0] INIT_LONG_WAIT = 16'd4100;
	localparam logic [15:0] INIT_MID_WAIT  = 16'd100;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_DELAY   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAR_DELAY   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_POWERUP_DELAY = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FUNCTION_SET  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DISPLAY_CTRL  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ENTRY_MODE    = 3'd5;

	// configuration reset values
	localparam logic [15:0] RST_SHORT_DELAY   = 16'd37;
	localparam logic [15:0] RST_CLEAR_DELAY   = 16'd1520;
	localparam logic [15:0] RST_POWERUP_DELAY = 16'd10000;
	localparam logic [7:0]  RST_FUNCTION_SET  = 8'h28;
	localparam logic [7:0]  RST_DISPLAY_CTRL  = 8'h0C;
	localparam logic [7:0]  RST_ENTRY_MODE    = 8'h06;

	// configuration register set
	typedef struct packed {
		logic [15:0] short_delay;
		logic [15:0] clear_delay;
		logic [15:0] powerup_delay;
		logic [7:0]  function_set;
		logic [7:0]  display_control;
		logic [7:0]  entry_mode;
	} cfg_t;

	// one tick's result
	typedef struct packed {
		logic       pin_rs;
		logic       pin_enable;
		logic [3:0] pin_data;
		logic       busy;
		logic       accepted;
		logic       refused;
	} res_t;

	// position within the init nibble groups: offset modulo three
	function automatic logic [1:0] init_phase(input logic [3:0] off);
		logic [1:0] r;
		r = 2'd0;
		for (int j = 0; j < 4; j++) begin
			if (off >= 4'(j * 3))
				r = 2'(off - 4'(j * 3));
		end
		return r;
	endfunction

	// byte slot and sub-step within the init bytes: offset split by seven
	function automatic logic [5:0] byte_split(input logic [5:0] off);
		logic [2:0] slot;
		logic [2:0] sub;
		slot = 3'd0;
		sub  = 3'd0;
		for (int j = 0; j < 5; j++) begin
			if (off >= 6'(j * 7)) begin
				slot = 3'(j);
				sub  = 3'(off - 6'(j * 7));
			end
		end
		return {slot, sub};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_nibble_interface_unit.sv =====
// top level of the character lcd nibble interface: input stage, sequencer, result stage
// path: a tick is registered in the input stage, and its result is then registered in the result stage
// throughput: one tick per cycle while the result side does not stall, set by the single-pass sequencer between stages
// stall on the result side backs up through the input stage without loss
// reset: sequencer to the power-up wait, configuration to defaults, stages empty
`default_nettype none

module char_lcd_nibble_interface_unit
	import lcdni_pkg::*;
#(
	parameter int WAIT_COUNTER_BITS = WAIT_COUNTER_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      request_valid,
	input  wire logic                      request_is_data,
	input  wire logic [7:0]                request_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           pin_rs,
	output logic                           pin_enable,
	output logic [3:0]                     pin_data,
	output logic                           busy_res,
	output logic                           accepted,
	output logic                           refused,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [15:0]               cfg_data
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_s2;
	logic       valid_s1, valid_s2;
	logic       rv_s1, rd_s1;
	logic [7:0] rb_s1;
	logic       adv_s2;
	logic       tick_en;

	lcdni_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage handshake
	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign tick_en  = valid_s1 && adv_s2;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rv_s1 <= request_valid;
			rd_s1 <= request_is_data;
			rb_s1 <= request_byte;
		end
	end

	lcdni_sequencer #(
		.WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick_en         (tick_en),
		.request_valid   (rv_s1),
		.request_is_data (rd_s1),
		.request_byte    (rb_s1),
		.cfg             (cfg),
		.res             (res)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign pin_rs     = res_s2.pin_rs;
	assign pin_enable = res_s2.pin_enable;
	assign pin_data   = res_s2.pin_data;
	assign busy_res   = res_s2.busy;
	assign accepted   = res_s2.accepted;
	assign refused    = res_s2.refused;

endmodule

`default_nettype wire

// ===== rtl/lcdni_cfg_regs.sv =====
// configuration register file of the character lcd nibble interface
`default_nettype none

module lcdni_cfg_regs
	import lcdni_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [15:0]               cfg_data,
	output cfg_t                           cfg
);

	// always able to take a write
	assign cfg_ready = 1'b1;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.short_delay     <= RST_SHORT_DELAY;
			cfg.clear_delay     <= RST_CLEAR_DELAY;
			cfg.powerup_delay   <= RST_POWERUP_DELAY;
			cfg.function_set    <= RST_FUNCTION_SET;
			cfg.display_control <= RST_DISPLAY_CTRL;
			cfg.entry_mode      <= RST_ENTRY_MODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SHORT_DELAY:   cfg.short_delay     <= cfg_data;
				CFG_CLEAR_DELAY:   cfg.clear_delay     <= cfg_data;
				CFG_POWERUP_DELAY: cfg.powerup_delay   <= cfg_data;
				CFG_FUNCTION_SET:  cfg.function_set    <= cfg_data[7:0];
				CFG_DISPLAY_CTRL:  cfg.display_control <= cfg_data[7:0];
				CFG_ENTRY_MODE:    cfg.entry_mode      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lcdni_sequencer.sv =====
// init and transfer sequencer: step, wait counter, held byte and pin state
`default_nettype none

module lcdni_sequencer
	import lcdni_pkg::*;
#(
	parameter int WAIT_COUNTER_BITS = WAIT_COUNTER_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tick_en,
	input  wire logic       request_valid,
	input  wire logic       request_is_data,
	input  wire logic [7:0] request_byte,
	input  wire cfg_t       cfg,
	output res_t            res
);

	localparam int DW = (WAIT_COUNTER_BITS > 16) ? WAIT_COUNTER_BITS : 16;
	localparam logic [DW-1:0] WAIT_LIM = DW'({WAIT_COUNTER_BITS{1'b1}});

	logic [SEQ_STEP_BITS-1:0]     step_q, step_d;
	logic [WAIT_COUNTER_BITS-1:0] cnt_q, cnt_d;
	logic [7:0]                   hbyte_q, hbyte_d;
	logic                         hrs_q, hrs_d;
	logic                         prs_q, prs_d;
	logic                         pen_q, pen_d;
	logic [3:0]                   pdat_q, pdat_d;

	// next state for one tick
	always_comb begin
		logic                         busy_in;
		logic                         do_wait;
		logic [15:0]                  dly;
		logic [SEQ_STEP_BITS-1:0]     wait_to;
		logic [SEQ_STEP_BITS-1:0]     byte_next;
		logic [2:0]                   bk;
		logic [5:0]                   split;
		logic [DW-1:0]                dx;
		logic [WAIT_COUNTER_BITS-1:0] cnt_base;

		step_d  = step_q;
		cnt_d   = cnt_q;
		hbyte_d = hbyte_q;
		hrs_d   = hrs_q;
		prs_d   = prs_q;
		pen_d   = pen_q;
		pdat_d  = pdat_q;
		do_wait = 1'b0;
		dly     = cfg.short_delay;
		wait_to = step_q;
		byte_next = step_q;
		bk      = BK_HI_SET;
		split   = '0;
		dx      = '0;
		cnt_base = '0;
		res     = '0;

		// request intake
		busy_in = step_q < STEP_IDLE;
		if (request_valid) begin
			if (busy_in) begin
				res.refused = 1'b1;
			end else begin
				hrs_d   = request_is_data;
				hbyte_d = request_byte;
				cnt_d   = '0;
				step_d  = STEP_USER;
				res.accepted = 1'b1;
			end
		end
		res.busy = step_d < STEP_IDLE;

		// sequence advance
		if (res.busy) begin
			if (step_d == STEP_POWERUP) begin
				prs_d   = 1'b0;
				pen_d   = 1'b0;
				pdat_d  = '0;
				do_wait = 1'b1;
				dly     = cfg.powerup_delay;
				wait_to = STEP_INIT_NIB;
			end else if (step_d < STEP_BYTES) begin
				hrs_d = 1'b0;
				case (init_phase(4'(step_d - STEP_INIT_NIB)))
					IN_SET: begin
						prs_d  = 1'b0;
						pen_d  = 1'b0;
						pdat_d = (step_d < STEP_LAST_NIB3) ? NIB_WAKE : NIB_FOURBIT;
						step_d = step_d + 1'b1;
					end
					IN_EN: begin
						pen_d  = 1'b1;
						step_d = step_d + 1'b1;
					end
					default: begin
						do_wait = 1'b1;
						wait_to = step_d + 1'b1;
						if (step_d == STEP_LONG_WAIT)
							dly = INIT_LONG_WAIT;
						else if (step_d == STEP_MID_WAIT)
							dly = INIT_MID_WAIT;
						else
							dly = cfg.short_delay;
					end
				endcase
			end else begin
				// byte transfer, init bytes first then the user byte
				if (step_d < STEP_USER) begin
					split = byte_split(step_d - STEP_BYTES);
					bk    = split[2:0];
					byte_next = (step_d == STEP_LAST_INIT) ? STEP_IDLE : step_d + 1'b1;
					if (bk == BK_HI_SET) begin
						hrs_d = 1'b0;
						case (split[5:3])
							IB_FUNCTION: hbyte_d = cfg.function_set;
							IB_DISPLAY:  hbyte_d = cfg.display_control;
							IB_ENTRY:    hbyte_d = cfg.entry_mode;
							IB_CLEAR:    hbyte_d = INSTR_CLEAR;
							default:     hbyte_d = INSTR_HOME;
						endcase
					end
				end else begin
					bk = 3'(step_d - STEP_USER);
					byte_next = (bk == BK_POST) ? STEP_IDLE : step_d + 1'b1;
				end
				case (bk)
					BK_HI_SET, BK_LO_SET: begin
						prs_d  = hrs_d;
						pen_d  = 1'b0;
						pdat_d = (bk == BK_HI_SET) ? hbyte_d[7:4] : hbyte_d[3:0];
						step_d = byte_next;
					end
					BK_HI_EN, BK_LO_EN: begin
						pen_d  = 1'b1;
						step_d = byte_next;
					end
					BK_HI_WAIT, BK_LO_WAIT: begin
						do_wait = 1'b1;
						dly     = cfg.short_delay;
						wait_to = byte_next;
					end
					default: begin
						do_wait = 1'b1;
						wait_to = byte_next;
						if (!hrs_d && (hbyte_d == INSTR_CLEAR || hbyte_d == INSTR_HOME))
							dly = cfg.clear_delay;
						else
							dly = cfg.short_delay;
					end
				endcase
			end

			// shared wait tick: load on zero with min one and clamp, then count down
			if (do_wait) begin
				pen_d = 1'b0;
				dx = DW'(dly);
				if (dx == '0)
					dx = DW'(1);
				if (dx > WAIT_LIM)
					dx = WAIT_LIM;
				cnt_base = (cnt_d == '0) ? WAIT_COUNTER_BITS'(dx) : cnt_d;
				cnt_d = cnt_base - 1'b1;
				if (cnt_d == '0)
					step_d = wait_to;
			end
		end

		res.pin_rs     = prs_d;
		res.pin_enable = pen_d;
		res.pin_data   = pdat_d;
	end

	// sequencer state, moved once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_POWERUP;
			cnt_q   <= '0;
			hbyte_q <= '0;
			hrs_q   <= 1'b0;
			prs_q   <= 1'b0;
			pen_q   <= 1'b0;
			pdat_q  <= '0;
		end else if (tick_en) begin
			step_q  <= step_d;
			cnt_q   <= cnt_d;
			hbyte_q <= hbyte_d;
			hrs_q   <= hrs_d;
			prs_q   <= prs_d;
			pen_q   <= pen_d;
			pdat_q  <= pdat_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lcdni_checker.sv =====
// port-level checker of the character lcd nibble interface and its bind
`default_nettype none

module lcdni_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       pin_enable,
	input wire logic [3:0] pin_data,
	input wire logic       busy_res,
	input wire logic       accepted,
	input wire logic       refused
);

	// a taken request starts a transfer and is never also dropped
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> busy_res && !refused)
		else $error("accepted request without busy or with refused");

	// a request is only dropped while busy
	a_refuse_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && refused |-> busy_res)
		else $error("refused request while idle");

	// the enable strobe only rises inside a sequence
	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pin_enable |-> busy_res)
		else $error("enable high while idle");

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pin_data))
		else $error("stalled result changed");

endmodule

bind char_lcd_nibble_interface_unit lcdni_checker u_lcdni_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pin_enable (pin_enable),
	.pin_data   (pin_data),
	.busy_res   (busy_res),
	.accepted   (accepted),
	.refused    (refused)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the character lcd nibble interface unit
`timescale 1ns / 100ps

module testbench;
	import lcdni_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int WAIT_BITS = WAIT_COUNTER_BITS_DEF;
	localparam logic [31:0] WAIT_LIM = (32'd1 << WAIT_BITS) - 32'd1;
	localparam int NIB_TICKS = IN_WAIT + 1;
	localparam int BYTE_TICKS = BK_POST + 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = CFG_ENTRY_MODE + 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic request_valid;
	logic request_is_data;
	logic [7:0] request_byte;
	logic out_valid;
	logic out_stall;
	logic pin_rs;
	logic pin_enable;
	logic [3:0] pin_data;
	logic busy_res;
	logic accepted;
	logic refused;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [15:0] cfg_data;

	// receiver stall is the random pause or the long hold-off
	logic rx_stall = 1'b0;
	logic hold_stall = 1'b0;
	int hold_left = 0;
	assign out_stall = rx_stall | hold_stall;

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int mismatch_count = 0;
	int results_seen = 0;
	int cycle_count = 0;

	// expected pin levels and flags, oldest first
	res_t pins_due[$];
	res_t pins_want;

	// shadow of the lcd sequencer
	logic [SEQ_STEP_BITS-1:0] lcd_step;
	logic [WAIT_BITS-1:0] lcd_wait;
	logic [7:0] lcd_byte;
	logic lcd_rs;
	logic pin_rs_q;
	logic pin_en_q;
	logic [3:0] pin_data_q;

	// shadow of the configuration registers
	logic [15:0] dly_short;
	logic [15:0] dly_clear;
	logic [15:0] dly_powerup;
	logic [7:0] byte_function;
	logic [7:0] byte_display;
	logic [7:0] byte_entry;

	char_lcd_nibble_interface_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.request_valid   (request_valid),
		.request_is_data (request_is_data),
		.request_byte    (request_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pin_rs          (pin_rs),
		.pin_enable      (pin_enable),
		.pin_data        (pin_data),
		.busy_res        (busy_res),
		.accepted        (accepted),
		.refused         (refused),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one tick of a wait, true on its last tick
	function automatic logic wait_done(input logic [15:0] dly);
		logic [31:0] d;
		pin_en_q = 1'b0;
		if (lcd_wait == '0) begin
			d = (dly == 16'd0) ? 32'd1 : 32'(dly);
			if (d > WAIT_LIM)
				d = WAIT_LIM;
			lcd_wait = d[WAIT_BITS-1:0];
		end
		lcd_wait = lcd_wait - 1'b1;
		return lcd_wait == '0;
	endfunction

	function automatic void set_nibble(input logic [3:0] nib);
		pin_data_q = nib;
		pin_rs_q = lcd_rs;
		pin_en_q = 1'b0;
	endfunction

	// one sub-step of a byte transfer, true when it is complete
	function automatic logic byte_step_done(input logic [2:0] k);
		case (k)
		BK_HI_SET: begin
			set_nibble(lcd_byte[7:4]);
			return 1'b1;
		end
		BK_LO_SET: begin
			set_nibble(lcd_byte[3:0]);
			return 1'b1;
		end
		BK_HI_EN, BK_LO_EN: begin
			pin_en_q = 1'b1;
			return 1'b1;
		end
		BK_HI_WAIT, BK_LO_WAIT:
			return wait_done(dly_short);
		default: begin
			// clear and home instructions need the long settle time
			if (!lcd_rs && (lcd_byte == INSTR_CLEAR || lcd_byte == INSTR_HOME))
				return wait_done(dly_clear);
			return wait_done(dly_short);
		end
		endcase
	endfunction

	function automatic void lcd_advance();
		int s;
		int off;
		logic [2:0] k;
		logic [15:0] d;
		s = lcd_step;
		if (s == STEP_POWERUP) begin
			{pin_rs_q, pin_en_q, pin_data_q} = '0;
			if (wait_done(dly_powerup))
				lcd_step = STEP_INIT_NIB;
		end else if (s < STEP_BYTES) begin
			// wake-up nibbles, each set, strobe, wait
			lcd_rs = 1'b0;
			case (2'((s - STEP_INIT_NIB) % NIB_TICKS))
			IN_SET: begin
				set_nibble(s < STEP_LAST_NIB3 ? NIB_WAKE : NIB_FOURBIT);
				lcd_step = lcd_step + 1'b1;
			end
			IN_EN: begin
				pin_en_q = 1'b1;
				lcd_step = lcd_step + 1'b1;
			end
			default: begin
				d = (s == STEP_LONG_WAIT) ? INIT_LONG_WAIT :
					(s == STEP_MID_WAIT) ? INIT_MID_WAIT : dly_short;
				if (wait_done(d))
					lcd_step = lcd_step + 1'b1;
			end
			endcase
		end else if (s < STEP_USER) begin
			// init instruction bytes
			off = s - STEP_BYTES;
			k = 3'(off % BYTE_TICKS);
			if (k == BK_HI_SET) begin
				lcd_rs = 1'b0;
				case (3'(off / BYTE_TICKS))
				IB_FUNCTION: lcd_byte = byte_function;
				IB_DISPLAY:  lcd_byte = byte_display;
				IB_ENTRY:    lcd_byte = byte_entry;
				IB_CLEAR:    lcd_byte = INSTR_CLEAR;
				default:     lcd_byte = INSTR_HOME;
				endcase
			end
			if (byte_step_done(k))
				lcd_step = (s == STEP_LAST_INIT) ? STEP_IDLE : lcd_step + 1'b1;
		end else if (s < STEP_IDLE) begin
			k = 3'(s - STEP_USER);
			if (byte_step_done(k))
				lcd_step = (k == BK_POST) ? STEP_IDLE : lcd_step + 1'b1;
		end
	endfunction

	// pin levels and flags after one tick
	function automatic res_t lcd_pins_after_tick(input logic req_v, input logic req_d,
			input logic [7:0] req_b);
		res_t r;
		r = '0;
		if (req_v) begin
			if (lcd_step < STEP_IDLE) begin
				r.refused = 1'b1;
			end else begin
				lcd_rs = req_d;
				lcd_byte = req_b;
				lcd_wait = '0;
				lcd_step = STEP_USER;
				r.accepted = 1'b1;
			end
		end
		r.busy = lcd_step < STEP_IDLE;
		if (r.busy)
			lcd_advance();
		r.pin_rs = pin_rs_q;
		r.pin_enable = pin_en_q;
		r.pin_data = pin_data_q;
		return r;
	endfunction

	function automatic void store_setting(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [15:0] val);
		case (idx)
		CFG_SHORT_DELAY:   dly_short = val;
		CFG_CLEAR_DELAY:   dly_clear = val;
		CFG_POWERUP_DELAY: dly_powerup = val;
		CFG_FUNCTION_SET:  byte_function = val[7:0];
		CFG_DISPLAY_CTRL:  byte_display = val[7:0];
		CFG_ENTRY_MODE:    byte_entry = val[7:0];
		default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
	endtask

	// check every result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pins_due.size() == 0) begin
				report_mismatch("result with nothing due", 1, 0);
			end else begin
				pins_want = pins_due.pop_front();
				if (pin_rs !== pins_want.pin_rs)
					report_mismatch("pin_rs", pin_rs, pins_want.pin_rs);
				if (pin_enable !== pins_want.pin_enable)
					report_mismatch("pin_enable", pin_enable, pins_want.pin_enable);
				if (pin_data !== pins_want.pin_data)
					report_mismatch("pin_data", pin_data, pins_want.pin_data);
				if (busy_res !== pins_want.busy)
					report_mismatch("busy_res", busy_res, pins_want.busy);
				if (accepted !== pins_want.accepted)
					report_mismatch("accepted", accepted, pins_want.accepted);
				if (refused !== pins_want.refused)
					report_mismatch("refused", refused, pins_want.refused);
			end
			results_seen++;
		end
	end

	// random receiver pause per result transfer
	initial begin : result_pacing
		int pause;
		forever begin
			pause = rx_idle ? $urandom_range(0, 6) : 0;
			if (pause > 0) begin
				@(negedge clk);
				rx_stall <= 1'b1;
				repeat (pause - 1) @(negedge clk);
			end
			@(negedge clk);
			rx_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
		end
	end

	// long receiver hold-off, counted down in cycles
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			hold_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// offer one tick and record its expected result once transferred
	task automatic send_tick(input logic req_v, input logic req_d, input logic [7:0] req_b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		request_valid <= req_v;
		request_is_data <= req_d;
		request_byte <= req_b;
		do @(posedge clk); while (in_stall);
		pins_due.push_back(lcd_pins_after_tick(req_v, req_d, req_b));
	endtask

	task automatic set_register(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		store_setting(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering and let every due result come out
	task automatic await_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pins_due.size() != 0)
			@(posedge clk);
	endtask

	// plain ticks until the sequencer is idle, with the odd refused request
	task automatic tick_until_idle(input int refuse_pct);
		while (lcd_step < STEP_IDLE)
			send_tick($urandom_range(0, 99) < refuse_pct, 1'($urandom), 8'($urandom));
	endtask

	task automatic run_byte(input logic req_d, input logic [7:0] req_b);
		send_tick(1'b1, req_d, req_b);
		tick_until_idle(4);
	endtask

	// mostly well-formed requests when idle, a few refused ones while busy
	task automatic random_tick(output bit counted);
		logic req_v;
		logic [7:0] b;
		if (lcd_step >= STEP_IDLE)
			req_v = $urandom_range(0, 9) < 8;
		else
			req_v = $urandom_range(0, 99) < 8;
		if ($urandom_range(0, 3) == 0)
			b = $urandom_range(0, 1) ? INSTR_HOME : INSTR_CLEAR;
		else
			b = 8'($urandom);
		counted = req_v || (lcd_step < STEP_IDLE);
		send_tick(req_v, 1'($urandom), b);
	endtask

	task automatic test_init_sequence();
		set_register(CFG_POWERUP_DELAY, 16'd0);
		set_register(CFG_SHORT_DELAY, 16'd2);
		set_register(CFG_CLEAR_DELAY, 16'd3);
		set_register(CFG_FUNCTION_SET, 16'h00FF);
		set_register(CFG_DISPLAY_CTRL, 16'h0000);
		set_register(CFG_ENTRY_MODE, 16'($urandom));
		tick_until_idle(3);
	endtask

	task automatic test_directed_bytes();
		// idle tick with no request holds the pins
		send_tick(1'b0, 1'b1, 8'hFF);
		run_byte(1'b0, 8'h00);
		run_byte(1'b1, 8'hFF);
		run_byte(1'b0, INSTR_CLEAR);
		run_byte(1'b0, INSTR_HOME);
		run_byte(1'b1, INSTR_CLEAR);
		run_byte(1'b1, INSTR_HOME);
		run_byte(1'b0, 8'h81);
		run_byte(1'b1, 8'h7E);
		// back-to-back requests: the second is refused
		send_tick(1'b1, 1'b1, 8'hA5);
		send_tick(1'b1, 1'b0, 8'h5A);
		tick_until_idle(0);
		run_byte(1'b0, 8'h03);
	endtask

	task automatic test_zero_delays();
		await_results();
		set_register(CFG_SHORT_DELAY, 16'd0);
		set_register(CFG_CLEAR_DELAY, 16'd0);
		run_byte(1'b0, INSTR_CLEAR);
		run_byte(1'b1, 8'h96);
		run_byte(1'b0, INSTR_HOME);
	endtask

	task automatic test_unknown_index();
		await_results();
		set_register(CFG_UNUSED_LO, 16'hFFFF);
		set_register(CFG_UNUSED_HI, 16'h0000);
		run_byte(1'b1, 8'h3C);
		run_byte(1'b0, INSTR_CLEAR);
	endtask

	task automatic test_input_backpressure();
		bit counted;
		await_results();
		set_register(CFG_SHORT_DELAY, 16'd3);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_left = 80;
		repeat (40) random_tick(counted);
		await_results();
	endtask

	task automatic test_random_traffic();
		int counted_items;
		bit counted;
		for (int phase = 0; phase < 4; phase++) begin
			await_results();
			tx_idle = (phase == 0) || (phase == 2);
			rx_idle = (phase == 0) || (phase == 3);
			set_register(CFG_SHORT_DELAY, (phase == 0) ? 16'd1 : 16'($urandom_range(1, 6)));
			set_register(CFG_CLEAR_DELAY, (phase == 0) ? 16'd1 : 16'($urandom_range(1, 12)));
			set_register(CFG_POWERUP_DELAY, 16'($urandom));
			set_register(CFG_FUNCTION_SET, 16'($urandom_range(0, 255)));
			set_register(CFG_DISPLAY_CTRL, 16'($urandom_range(0, 255)));
			set_register(CFG_ENTRY_MODE, 16'($urandom_range(0, 255)));
			counted_items = 0;
			while (counted_items < 240) begin
				random_tick(counted);
				if (counted)
					counted_items++;
				// sender pauses once until everything due has come out
				if (phase == 2 && counted_items == 120)
					await_results();
			end
		end
	endtask

	task automatic test_long_delays();
		await_results();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		set_register(CFG_SHORT_DELAY, 16'd300);
		set_register(CFG_CLEAR_DELAY, 16'd500);
		run_byte(1'b0, INSTR_CLEAR);
		await_results();
		set_register(CFG_SHORT_DELAY, RST_SHORT_DELAY);
		set_register(CFG_POWERUP_DELAY, 16'hFFFF);
		run_byte(1'b1, 8'h42);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		request_valid = 1'b0;
		request_is_data = 1'b0;
		request_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = CFG_SHORT_DELAY;
		cfg_data = 16'h0000;
		// shadow state at its reset values
		lcd_step = STEP_POWERUP;
		lcd_wait = '0;
		lcd_byte = 8'h00;
		lcd_rs = 1'b0;
		{pin_rs_q, pin_en_q, pin_data_q} = '0;
		dly_short = RST_SHORT_DELAY;
		dly_clear = RST_CLEAR_DELAY;
		dly_powerup = RST_POWERUP_DELAY;
		byte_function = RST_FUNCTION_SET;
		byte_display = RST_DISPLAY_CTRL;
		byte_entry = RST_ENTRY_MODE;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_init_sequence();
		test_directed_bytes();
		test_zero_delays();
		test_unknown_index();
		test_input_backpressure();
		test_random_traffic();
		test_long_delays();

		await_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lcdni_pkg.sv
rtl/lcdni_cfg_regs.sv
rtl/lcdni_sequencer.sv
rtl/char_lcd_nibble_interface_unit.sv
rtl/lcdni_checker.sv
tb/testbench.sv
